// ===== design/segment_intersection_assert.svh =====
// Assertion macros shared by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH

`ifndef ASSERT_OFF
`define SI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SI_ASSERT(label, clk, rst_n, prop, msg)
`define SI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== design/si_pkg.sv =====
`default_nettype none
package si_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MIN_DET_WIDTH   = 16;
  localparam logic [MIN_DET_WIDTH-1:0] MIN_DET_RESET = 16'd1;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic has_room;
    logic has_data;
  } q_stat_t;
endpackage
`default_nettype wire

// ===== design/si_front.sv =====
`default_nettype none
module si_front #(
  parameter int CW = si_pkg::COORD_WIDTH_DEF,
  parameter int DW = CW + 1,
  parameter int PW = 2 * DW + 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [CW-1:0]           ax,
  input  wire logic signed [CW-1:0]           ay,
  input  wire logic signed [CW-1:0]           bx,
  input  wire logic signed [CW-1:0]           by,
  input  wire logic signed [CW-1:0]           cx,
  input  wire logic signed [CW-1:0]           cy,
  input  wire logic signed [CW-1:0]           ex,
  input  wire logic signed [CW-1:0]           ey,
  input  wire logic [si_pkg::MIN_DET_WIDTH-1:0] min_det,
  input  wire si_pkg::q_stat_t                q_stat,
  output logic                                push,
  output logic                                push_hit,
  output logic signed [PW-1:0]                push_det,
  output logic signed [PW-1:0]                push_na,
  output logic signed [CW-1:0]                push_ax,
  output logic signed [CW-1:0]                push_ay,
  output logic signed [DW-1:0]                push_dx1,
  output logic signed [DW-1:0]                push_dy1
);
  logic en;
  logic v1_r, v2_r, v3_r;
  logic signed [CW-1:0] ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r, ox_r, oy_r;
  logic signed [DW-1:0] dx1_2_r, dy1_2_r, dx1_3_r, dy1_3_r;
  logic signed [2*DW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [PW-1:0] det_r, na_r, nb_r;
  logic [PW-1:0] det_mag;
  logic na_in, nb_in;

  assign en       = !v3_r || q_stat.has_room;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r   <= ax;
      ay1_r   <= ay;
      dx1_r   <= DW'(bx) - DW'(ax);
      dy1_r   <= DW'(by) - DW'(ay);
      dx2_r   <= DW'(ex) - DW'(cx);
      dy2_r   <= DW'(ey) - DW'(cy);
      ox_r    <= DW'(ax) - DW'(cx);
      oy_r    <= DW'(ay) - DW'(cy);
      pa_r    <= dx1_r * dy2_r;
      pb_r    <= dy1_r * dx2_r;
      pc_r    <= oy_r * dx2_r;
      pd_r    <= ox_r * dy2_r;
      pe_r    <= oy_r * dx1_r;
      pf_r    <= ox_r * dy1_r;
      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
      dx1_2_r <= dx1_r;
      dy1_2_r <= dy1_r;
      det_r   <= PW'(pa_r) - PW'(pb_r);
      na_r    <= PW'(pc_r) - PW'(pd_r);
      nb_r    <= PW'(pe_r) - PW'(pf_r);
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      dx1_3_r <= dx1_2_r;
      dy1_3_r <= dy1_2_r;
    end
  end

  // Parameter tests 0 < n/det < 1 done on the numerators, sign aware.
  assign det_mag = det_r[PW-1] ? PW'(-det_r) : PW'(det_r);
  assign na_in = (det_r > 0) ? (na_r > 0 && na_r < det_r) : (na_r < 0 && na_r > det_r);
  assign nb_in = (det_r > 0) ? (nb_r > 0 && nb_r < det_r) : (nb_r < 0 && nb_r > det_r);

  assign push     = v3_r && q_stat.has_room;
  assign push_hit = (det_r != '0) && (det_mag >= PW'(min_det)) && na_in && nb_in;
  assign push_det = det_r;
  assign push_na  = na_r;
  assign push_ax  = ax3_r;
  assign push_ay  = ay3_r;
  assign push_dx1 = dx1_3_r;
  assign push_dy1 = dy1_3_r;
endmodule
`default_nettype wire

// ===== design/si_queue.sv =====
`default_nettype none
module si_queue #(
  parameter int QW = 8,
  parameter int QD = si_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [QW-1:0] push_data,
  input  wire logic          pop,
  output logic [QW-1:0]      pop_data,
  output si_pkg::q_stat_t    q_stat
);
  localparam int PTRW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNTW = $clog2(QD + 1);

  logic [QW-1:0]   mem [QD];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign q_stat.has_room = cnt_r != CNTW'(QD);
  assign q_stat.has_data = cnt_r != '0;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(QD - 1)) ? '0 : wr_ptr_r + PTRW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(QD - 1)) ? '0 : rd_ptr_r + PTRW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

`include "segment_intersection_assert.svh"
  `SI_ASSERT(a_no_overflow, clk, rst_n, push |-> q_stat.has_room, "queue push while full")
  `SI_ASSERT(a_no_underflow, clk, rst_n, pop |-> q_stat.has_data, "queue pop while empty")
  `SI_ASSERT(a_cnt_up, clk, rst_n, (push && !pop) |=> cnt_r == $past(cnt_r) + CNTW'(1), "no rise")
  `SI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> cnt_r == '0, "queue not empty after reset")
endmodule
`default_nettype wire

// ===== design/si_div.sv =====
`default_nettype none
module si_div #(
  parameter int CW = si_pkg::COORD_WIDTH_DEF,
  parameter int PW = 2 * CW + 3,
  parameter int TW = 3 * CW + 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire logic [TW-1:0] num,
  input  wire logic [PW-1:0] den,
  input  wire logic [1:0]    in_tag,
  output logic               out_v,
  output logic [CW-1:0]      quo,
  output logic [1:0]         out_tag
);
  // Restoring division, one quotient bit per stage; quotient < 2^CW.
  logic [TW-1:0] rem_r [CW+1];
  logic [PW-1:0] den_r [CW+1];
  logic [CW-1:0] q_r   [CW+1];
  logic [1:0]    tag_r [CW+1];
  logic [CW:0]   v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar j = 1; j <= CW; j++) begin : g_stage
    logic [TW-1:0] sub;
    logic          fits;
    assign sub  = TW'(den_r[j-1]) << (CW - j);
    assign fits = rem_r[j-1] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= fits ? rem_r[j-1] - sub : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= q_r[j-1] | (CW'(fits) << (CW - j));
        tag_r[j] <= tag_r[j-1];
      end
    end
  end

  assign out_v   = v_r[CW];
  assign quo     = q_r[CW];
  assign out_tag = tag_r[CW];
endmodule
`default_nettype wire

// ===== design/si_back.sv =====
`default_nettype none
module si_back #(
  parameter int CW = si_pkg::COORD_WIDTH_DEF,
  parameter int DW = CW + 1,
  parameter int PW = 2 * DW + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire si_pkg::q_stat_t      q_stat,
  output logic                      pop,
  input  wire logic                 hit,
  input  wire logic signed [PW-1:0] det,
  input  wire logic signed [PW-1:0] na,
  input  wire logic signed [CW-1:0] ax,
  input  wire logic signed [CW-1:0] ay,
  input  wire logic signed [DW-1:0] dx1,
  input  wire logic signed [DW-1:0] dy1,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_hit,
  output logic signed [CW-1:0]      out_cross_x,
  output logic signed [CW-1:0]      out_cross_y
);
  localparam int TW = PW + DW + 1;

  logic en;
  logic v1_r, v2_r, out_valid_r;
  logic hit1_r, hit2_r;
  logic signed [PW-1:0] det1_r;
  logic signed [CW+PW-1:0] bx_r, by_r;
  logic signed [PW+DW-1:0] nx_r, ny_r;
  logic signed [TW-1:0] tot_x, tot_y;
  logic [TW-1:0] mag_x_r, mag_y_r;
  logic [PW-1:0] den_r;
  logic neg_x_r, neg_y_r;
  logic dv_x, dv_y;
  logic [CW-1:0] q_x, q_y;
  logic [1:0] tag_x, tag_y;
  logic hit_o_r;
  logic signed [CW-1:0] cx_r, cy_r;

  assign en  = !(out_valid_r && out_stall);
  assign pop = en && q_stat.has_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      out_valid_r <= dv_x;
    end
  end

  assign tot_x = TW'(bx_r) + TW'(nx_r);
  assign tot_y = TW'(by_r) + TW'(ny_r);

  always_ff @(posedge clk) begin
    if (en) begin
      hit1_r  <= hit;
      det1_r  <= det;
      bx_r    <= ax * det;
      by_r    <= ay * det;
      nx_r    <= na * dx1;
      ny_r    <= na * dy1;
      hit2_r  <= hit1_r;
      mag_x_r <= tot_x[TW-1] ? TW'(-tot_x) : TW'(tot_x);
      mag_y_r <= tot_y[TW-1] ? TW'(-tot_y) : TW'(tot_y);
      den_r   <= det1_r[PW-1] ? PW'(-det1_r) : PW'(det1_r);
      neg_x_r <= tot_x[TW-1] != det1_r[PW-1];
      neg_y_r <= tot_y[TW-1] != det1_r[PW-1];
      hit_o_r <= tag_x[0];
      cx_r    <= !tag_x[0] ? '0 : (tag_x[1] ? CW'(-q_x) : CW'(q_x));
      cy_r    <= !tag_y[0] ? '0 : (tag_y[1] ? CW'(-q_y) : CW'(q_y));
    end
  end

  si_div #(.CW(CW), .PW(PW), .TW(TW)) u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (v2_r),
    .num    (mag_x_r),
    .den    (den_r),
    .in_tag ({neg_x_r, hit2_r}),
    .out_v  (dv_x),
    .quo    (q_x),
    .out_tag(tag_x)
  );

  si_div #(.CW(CW), .PW(PW), .TW(TW)) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (v2_r),
    .num    (mag_y_r),
    .den    (den_r),
    .in_tag ({neg_y_r, hit2_r}),
    .out_v  (dv_y),
    .quo    (q_y),
    .out_tag(tag_y)
  );

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_o_r;
  assign out_cross_x = cx_r;
  assign out_cross_y = cy_r;

`include "segment_intersection_assert.svh"
  `SI_ASSERT(a_div_lockstep, clk, rst_n, dv_x == dv_y, "divider pipelines out of step")
endmodule
`default_nettype wire

// ===== design/segment_intersection.sv =====
`default_nettype none
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid / in_stall | two segments, eight signed coordinates
// out_     | output    | out_valid/out_stall | hit flag and crossing point
// cfg_     | input     | cfg_valid/cfg_ready | min_determinant, 16 bits
//
// One segment pair is accepted per cycle unless in_stall is high; results leave in
// order, one per cycle unless the output stalls. A result passes from its input
// transfer through two front stages after capture, the queue write, two back stages,
// the divider input register, one divider stage per quotient bit and output register.
// Synchronous active-low reset empties every stage and the queue; min_determinant is 1.
// An output stall freezes the back part; the front fills the queue, then stalls the input.
module segment_intersection #(
  parameter int COORD_WIDTH = si_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = si_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_end_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic signed [COORD_WIDTH-1:0]      out_cross_x,
  output logic signed [COORD_WIDTH-1:0]      out_cross_y,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [si_pkg::MIN_DET_WIDTH-1:0] cfg_min_determinant
);
  // Deltas carry one extra bit; determinant and numerators are a difference
  // of two delta products.
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW + 1;
  localparam int QW = 1 + 2 * PW + 2 * COORD_WIDTH + 2 * DW;

  logic [si_pkg::MIN_DET_WIDTH-1:0] min_det_r;
  si_pkg::q_stat_t q_stat;
  logic push, pop, f_hit, b_hit;
  logic signed [PW-1:0] f_det, f_na, b_det, b_na;
  logic signed [COORD_WIDTH-1:0] f_ax, f_ay, b_ax, b_ay;
  logic signed [DW-1:0] f_dx1, f_dy1, b_dx1, b_dy1;
  logic [QW-1:0] q_in, q_out;

  // The register takes a transfer in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_det_r <= si_pkg::MIN_DET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_det_r <= cfg_min_determinant;
    end
  end

  si_front #(.CW(COORD_WIDTH), .DW(DW), .PW(PW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .ax      (in_first_start_x),
    .ay      (in_first_start_y),
    .bx      (in_first_end_x),
    .by      (in_first_end_y),
    .cx      (in_second_start_x),
    .cy      (in_second_start_y),
    .ex      (in_second_end_x),
    .ey      (in_second_end_y),
    .min_det (min_det_r),
    .q_stat  (q_stat),
    .push    (push),
    .push_hit(f_hit),
    .push_det(f_det),
    .push_na (f_na),
    .push_ax (f_ax),
    .push_ay (f_ay),
    .push_dx1(f_dx1),
    .push_dy1(f_dy1)
  );

  assign q_in = {f_hit, f_det, f_na, f_ax, f_ay, f_dx1, f_dy1};

  si_queue #(.QW(QW), .QD(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(q_in),
    .pop      (pop),
    .pop_data (q_out),
    .q_stat   (q_stat)
  );

  assign {b_hit, b_det, b_na, b_ax, b_ay, b_dx1, b_dy1} = q_out;

  si_back #(.CW(COORD_WIDTH), .DW(DW), .PW(PW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop        (pop),
    .hit        (b_hit),
    .det        (b_det),
    .na         (b_na),
    .ax         (b_ax),
    .ay         (b_ay),
    .dx1        (b_dx1),
    .dy1        (b_dy1),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_hit    (out_hit),
    .out_cross_x(out_cross_x),
    .out_cross_y(out_cross_y)
  );
endmodule
`default_nettype wire
